// ===== hdl/gsb_pkg.sv =====
// ----------------------------------------------------------------------------
// gsb_pkg: shared types and constants for the gyro scale and bias removal
// Field widths, fixed-point scale factors, state codes and register codes.
// ----------------------------------------------------------------------------
package gsb_pkg;

  // Field widths
  localparam int COUNT_W = 16;
  localparam int TEMP_W  = 8;
  localparam int RATE_W  = 32;
  localparam int CENTI_W = 16;
  localparam int RANGE_W = 2;
  localparam int TOFF_W  = 7;

  // Datapath widths
  localparam int K_W     = 31;  // Q40 scale factor, unsigned
  localparam int BIAS_W  = 48;  // Q36 bias estimate, signed
  localparam int DIFF_W  = BIAS_W + 1;
  localparam int MUL_A_W = DIFF_W;
  localparam int MUL_B_W = 20;

  localparam int AXES    = 3;
  localparam int AXIS_W  = 2;

  // Bus widths
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Moving average gain, about 1e-4 in units of 2^-32
  localparam logic [MUL_B_W-1:0] EMA_GAIN = MUL_B_W'(429497);

  // Rounding constant for the Q36 to Q24 step
  localparam logic [DIFF_W-1:0] RATE_ROUND = DIFF_W'(2048);

  // Pi in Q40, and rad/s per digit in Q40 for each full scale range
  localparam logic [63:0] PI_Q40    = 64'h3243F6A8885A308D >> 20;
  localparam logic [63:0] RATE_DIV  = 64'd18000000;
  localparam logic [63:0] K_250_W   = (64'd875 * PI_Q40 + RATE_DIV / 2) / RATE_DIV;
  localparam logic [63:0] K_500_W   = (64'd1750 * PI_Q40 + RATE_DIV / 2) / RATE_DIV;
  localparam logic [63:0] K_2000_W  = (64'd7000 * PI_Q40 + RATE_DIV / 2) / RATE_DIV;
  localparam logic [K_W-1:0] K_250  = K_250_W[K_W-1:0];
  localparam logic [K_W-1:0] K_500  = K_500_W[K_W-1:0];
  localparam logic [K_W-1:0] K_2000 = K_2000_W[K_W-1:0];

  // Range codes
  localparam logic [RANGE_W-1:0] RANGE_250  = 2'd0;
  localparam logic [RANGE_W-1:0] RANGE_500  = 2'd1;
  localparam logic [RANGE_W-1:0] RANGE_2000 = 2'd2;

  // Register reset values
  localparam logic [RANGE_W-1:0] RANGE_RST = RANGE_500;
  localparam logic [TOFF_W-1:0]  TOFF_RST  = 7'd25;

  // Register map (index taken from paddr bit 2)
  typedef enum logic {
    REG_RANGE       = 1'b0,
    REG_TEMP_OFFSET = 1'b1
  } gsb_reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE_START,
    ST_SCALE_RUN,
    ST_GAIN_START,
    ST_GAIN_RUN,
    ST_DONE
  } gsb_state_e;

  // Configuration handed from the register block to the datapath
  typedef struct packed {
    logic [RANGE_W-1:0] range_sel;
    logic [TOFF_W-1:0]  temp_offset;
  } gsb_cfg_t;

  // Pick the scale factor; the unused range code falls back to 500 dps
  function automatic logic [K_W-1:0] scale_k(input logic [RANGE_W-1:0] range_sel);
    logic [K_W-1:0] k;
    case (range_sel)
      RANGE_250:  k = K_250;
      RANGE_2000: k = K_2000;
      default:    k = K_500;
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/gsb_serial_mul.sv =====
// ----------------------------------------------------------------------------
// gsb_serial_mul: bit-serial signed multiplier
// Takes one multiplier bit per cycle, LSB first, and shifts the partial
// product right; the full product is {hi_o, lo_o} once done_o pulses.
// ----------------------------------------------------------------------------
module gsb_serial_mul #(
  parameter int A_W = gsb_pkg::MUL_A_W,
  parameter int B_W = gsb_pkg::MUL_B_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [A_W-1:0] a_i,
  input  logic signed [B_W-1:0] b_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic signed [A_W-1:0] hi_o,
  output logic [B_W-1:0]        lo_o
);

  localparam int CNT_W = $clog2(B_W);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic signed [A_W-1:0] acc_q;
  logic signed [A_W-1:0] a_q;
  logic [B_W-1:0]        b_q;
  logic [B_W-1:0]        lo_q;

  logic                  last;
  logic signed [A_W:0]   a_ext;
  logic signed [A_W:0]   addend;
  logic signed [A_W:0]   sum;

  // Add or, for the sign bit of the multiplier, subtract the multiplicand
  always_comb begin
    last   = (cnt_q == CNT_W'(B_W - 1));
    a_ext  = {a_q[A_W-1], a_q};
    addend = '0;
    if (b_q[0]) begin
      addend = last ? -a_ext : a_ext;
    end
    sum = {acc_q[A_W-1], acc_q} + addend;
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q & last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Shift the partial product right; dropped bits form the low word
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
      lo_q  <= '0;
    end else if (busy_q) begin
      acc_q <= sum[A_W:1];
      lo_q  <= {sum[0], lo_q[B_W-1:1]};
      b_q   <= {1'b0, b_q[B_W-1:1]};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign hi_o   = acc_q;
  assign lo_o   = lo_q;

endmodule

// ===== hdl/gsb_apb_regs.sv =====
// ----------------------------------------------------------------------------
// gsb_apb_regs: configuration registers on an APB-style port
// Holds the full scale range and the temperature reference.
// ----------------------------------------------------------------------------
module gsb_apb_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gsb_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [gsb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [gsb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output gsb_pkg::gsb_cfg_t               cfg_o
);

  logic [gsb_pkg::RANGE_W-1:0] range_q;
  logic [gsb_pkg::TOFF_W-1:0]  toff_q;
  gsb_pkg::gsb_reg_e           reg_idx;
  logic                        wr_en;

  assign reg_idx = gsb_pkg::gsb_reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Write on the access cycle, keep the low bits of the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= gsb_pkg::RANGE_RST;
      toff_q  <= gsb_pkg::TOFF_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        gsb_pkg::REG_RANGE:       range_q <= pwdata[gsb_pkg::RANGE_W-1:0];
        gsb_pkg::REG_TEMP_OFFSET: toff_q  <= pwdata[gsb_pkg::TOFF_W-1:0];
        default:                  ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      gsb_pkg::REG_RANGE:       prdata = gsb_pkg::APB_DATA_W'(range_q);
      gsb_pkg::REG_TEMP_OFFSET: prdata = gsb_pkg::APB_DATA_W'(toff_q);
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o.range_sel   = range_q;
  assign cfg_o.temp_offset = toff_q;

endmodule

// ===== hdl/gyro_scale_and_bias_removal.sv =====
// ----------------------------------------------------------------------------
// gyro_scale_and_bias_removal: gyro rate scaling with moving-average bias
// Scales three axis counts to Q7.24 rad/s, tracks and removes a per-axis
// bias, and converts the temperature byte to hundredths of a degree.
// ----------------------------------------------------------------------------
// One sample is taken at a time. For each of the three axes the block runs
// one 20-step multiply of the count by the range scale factor and one 20-step
// multiply of the bias error by the averaging gain, both on a single shared
// bit-serial multiplier. Each multiply is a start state, 20 steps and a done
// pulse; after the last axis the result is loaded into the output register
// once that register is free. The finished word sits in that output register,
// so the next sample can be accepted from the cycle after the load, while the
// word waits to be taken. The bias estimates reset to zero; configuration writes
// should be made while no sample is in flight.
module gyro_scale_and_bias_removal (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Sample channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [gsb_pkg::COUNT_W-1:0]     x_count_i,
  input  logic signed [gsb_pkg::COUNT_W-1:0]     y_count_i,
  input  logic signed [gsb_pkg::COUNT_W-1:0]     z_count_i,
  input  logic signed [gsb_pkg::TEMP_W-1:0]      temp_count_i,
  // Result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [gsb_pkg::RATE_W-1:0]      x_rate_o,
  output logic signed [gsb_pkg::RATE_W-1:0]      y_rate_o,
  output logic signed [gsb_pkg::RATE_W-1:0]      z_rate_o,
  output logic signed [gsb_pkg::CENTI_W-1:0]     temp_centi_o,
  // Configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [gsb_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [gsb_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [gsb_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  localparam int AW = gsb_pkg::MUL_A_W;
  localparam int BW = gsb_pkg::MUL_B_W;

  gsb_pkg::gsb_cfg_t   cfg;
  gsb_pkg::gsb_state_e state_q, state_d;

  logic [gsb_pkg::AXIS_W-1:0]         axis_q;
  logic signed [gsb_pkg::COUNT_W-1:0] count_q [gsb_pkg::AXES];
  logic signed [gsb_pkg::TEMP_W-1:0]  temp_q;
  logic signed [gsb_pkg::BIAS_W-1:0]  bias_q  [gsb_pkg::AXES];
  logic signed [gsb_pkg::BIAS_W-1:0]  scaled_q;
  logic signed [gsb_pkg::RATE_W-1:0]  rate_q  [gsb_pkg::AXES];

  logic                               out_valid_q;
  logic signed [gsb_pkg::RATE_W-1:0]  x_rate_q, y_rate_q, z_rate_q;
  logic signed [gsb_pkg::CENTI_W-1:0] temp_centi_q;

  // Sequencer outputs
  logic in_accept;
  logic mul_start;
  logic mul_sel_gain;
  logic scale_we;
  logic axis_we;
  logic axis_clr;
  logic out_load;

  // Multiplier
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic                 mul_busy;
  logic                 mul_done;
  logic signed [AW-1:0] mul_hi;
  logic [BW-1:0]        mul_lo;

  // Datapath
  logic [gsb_pkg::K_W-1:0]           scale_k;
  logic signed [gsb_pkg::BIAS_W-1:0] bias_cur;
  logic signed [AW-1:0]              bias_err;
  logic signed [AW-1:0]              bias_inc;
  logic signed [gsb_pkg::BIAS_W-1:0] bias_new;
  logic signed [AW-1:0]              rate_diff;
  logic signed [AW-1:0]              rate_rnd;
  logic signed [9:0]                 temp_diff;
  logic signed [gsb_pkg::CENTI_W-1:0] temp_ext;
  logic signed [gsb_pkg::CENTI_W-1:0] temp_centi;

  gsb_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gsb_serial_mul #(
    .A_W (AW),
    .B_W (BW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .hi_o    (mul_hi),
    .lo_o    (mul_lo)
  );

  // Operand select: count times scale, then bias error times gain
  always_comb begin
    scale_k  = gsb_pkg::scale_k(cfg.range_sel);
    bias_cur = bias_q[axis_q];
    bias_err = {scaled_q[gsb_pkg::BIAS_W-1], scaled_q}
             - {bias_cur[gsb_pkg::BIAS_W-1], bias_cur};
    if (mul_sel_gain) begin
      mul_a = bias_err;
      mul_b = gsb_pkg::EMA_GAIN;
    end else begin
      mul_a = AW'(scale_k);
      mul_b = BW'(count_q[axis_q]);
    end
  end

  // Bias update, then Q36 to Q24 with round half up
  always_comb begin
    bias_inc  = mul_hi >>> 12;
    bias_new  = bias_cur + bias_inc[gsb_pkg::BIAS_W-1:0];
    rate_diff = {scaled_q[gsb_pkg::BIAS_W-1], scaled_q}
              - {bias_new[gsb_pkg::BIAS_W-1], bias_new};
    rate_rnd  = rate_diff + gsb_pkg::RATE_ROUND;
  end

  // Temperature: (reference - raw) * 100 as shifts and adds
  always_comb begin
    temp_diff  = $signed({3'b000, cfg.temp_offset}) - 10'(temp_q);
    temp_ext   = gsb_pkg::CENTI_W'(temp_diff);
    temp_centi = (temp_ext <<< 6) + (temp_ext <<< 5) + (temp_ext <<< 2);
  end

  // Sequencer: next state and controls
  always_comb begin
    state_d      = state_q;
    in_stall_o   = 1'b1;
    in_accept    = 1'b0;
    mul_start    = 1'b0;
    mul_sel_gain = 1'b0;
    scale_we     = 1'b0;
    axis_we      = 1'b0;
    axis_clr     = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      gsb_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          in_accept = 1'b1;
          axis_clr  = 1'b1;
          state_d   = gsb_pkg::ST_SCALE_START;
        end
      end
      gsb_pkg::ST_SCALE_START: begin
        mul_start = 1'b1;
        state_d   = gsb_pkg::ST_SCALE_RUN;
      end
      gsb_pkg::ST_SCALE_RUN: begin
        if (mul_done) begin
          scale_we = 1'b1;
          state_d  = gsb_pkg::ST_GAIN_START;
        end
      end
      gsb_pkg::ST_GAIN_START: begin
        mul_sel_gain = 1'b1;
        mul_start    = 1'b1;
        state_d      = gsb_pkg::ST_GAIN_RUN;
      end
      gsb_pkg::ST_GAIN_RUN: begin
        mul_sel_gain = 1'b1;
        if (mul_done) begin
          axis_we = 1'b1;
          if (axis_q == gsb_pkg::AXIS_W'(gsb_pkg::AXES - 1)) begin
            state_d = gsb_pkg::ST_DONE;
          end else begin
            state_d = gsb_pkg::ST_SCALE_START;
          end
        end
      end
      gsb_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = gsb_pkg::ST_IDLE;
        end
      end
      default: state_d = gsb_pkg::ST_IDLE;
    endcase
  end

  // State, axis counter and bias estimates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gsb_pkg::ST_IDLE;
      axis_q  <= '0;
      for (int i = 0; i < gsb_pkg::AXES; i++) begin
        bias_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (axis_clr) begin
        axis_q <= '0;
      end else if (axis_we) begin
        bias_q[axis_q] <= bias_new;
        // Wrap back to the first axis after the last one
        if (axis_q == gsb_pkg::AXIS_W'(gsb_pkg::AXES - 1)) begin
          axis_q <= '0;
        end else begin
          axis_q <= axis_q + gsb_pkg::AXIS_W'(1);
        end
      end
    end
  end

  // Capture the sample, the scaled rate and each corrected rate
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      count_q[0] <= x_count_i;
      count_q[1] <= y_count_i;
      count_q[2] <= z_count_i;
      temp_q     <= temp_count_i;
    end
    if (scale_we) begin
      scaled_q <= {mul_hi[gsb_pkg::BIAS_W-BW+3:0], mul_lo[BW-1:4]};
    end
    if (axis_we) begin
      rate_q[axis_q] <= rate_rnd[gsb_pkg::RATE_W+11:12];
    end
  end

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      x_rate_q     <= rate_q[0];
      y_rate_q     <= rate_q[1];
      z_rate_q     <= rate_q[2];
      temp_centi_q <= temp_centi;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign x_rate_o     = x_rate_q;
  assign y_rate_o     = y_rate_q;
  assign z_rate_o     = z_rate_q;
  assign temp_centi_o = temp_centi_q;

  // Never restart the multiplier in the middle of a product
  a_mul_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  // A finished product only arrives while the sequencer waits for one
  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == gsb_pkg::ST_SCALE_RUN || state_q == gsb_pkg::ST_GAIN_RUN))
    else $error("multiplier done outside a wait state");

  // Axis counter stays on a real axis
  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q != gsb_pkg::AXIS_W'(gsb_pkg::AXES))
    else $error("axis counter out of range");

  // A new word is loaded only when the previous one has left
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> !$fell(out_valid_q) && $stable(x_rate_q))
    else $error("pending output word overwritten");

endmodule
